>>> sv/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DefaultQueueDepth = 16;
  localparam int unsigned DataWidth         = 32;
  localparam int unsigned PrioWidth         = 16;
  localparam int unsigned TotalWidth        = 5;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic exec;   // run the accepted word and load the result register
  } spq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

>>> sv/spq_ctrl.sv
// Handshake controller of the sorted priority queue.
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  input  spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_cmd_t  cmd_o
);
  import spq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;
  logic        res_busy;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (!res_stall_i && !accept) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_busy    = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        res_busy    = 1'b0;
        res_valid_o = 1'b0;
      end
      S_HOLD: begin
        res_busy    = res_stall_i;
        res_valid_o = 1'b1;
      end
      default: begin
        res_busy    = 1'b0;
        res_valid_o = 1'b0;
      end
    endcase
    // A full or empty queue still takes the word; only a held result blocks.
    in_stall_o = res_busy && (stat_i.full || stat_i.empty || 1'b1);
    cmd_o.exec = in_valid_i && !in_stall_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/spq_datapath.sv
// Shift-register slots, count and result register of the sorted priority queue.
module spq_datapath #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DefaultQueueDepth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  spq_pkg::spq_cmd_t                      cmd_i,
  output spq_pkg::spq_stat_t                     stat_o,
  input  logic                                   mode_i,
  input  logic signed [spq_pkg::DataWidth-1:0]   item_data_i,
  input  logic        [spq_pkg::PrioWidth-1:0]   item_priority_i,
  output logic signed [spq_pkg::DataWidth-1:0]   out_data_o,
  output logic        [spq_pkg::PrioWidth-1:0]   out_priority_o,
  output logic                                   out_valid_o,
  output logic        [spq_pkg::TotalWidth-1:0]  entry_total_o,
  output logic        [1:0]                      status_o
);
  import spq_pkg::*;

  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);

  logic signed [DataWidth-1:0] slot_data_q     [QUEUE_DEPTH];
  logic signed [DataWidth-1:0] slot_data_d     [QUEUE_DEPTH];
  logic        [PrioWidth-1:0] slot_priority_q [QUEUE_DEPTH];
  logic        [PrioWidth-1:0] slot_priority_d [QUEUE_DEPTH];
  logic        [CntWidth-1:0]  count_q, count_d;
  logic        [QUEUE_DEPTH-1:0] less;
  logic                        full, empty;

  logic signed [DataWidth-1:0] res_data_d;
  logic        [PrioWidth-1:0] res_prio_d;
  logic                        res_ovalid_d;
  status_e                     res_status_d;
  status_e                     res_status_q;
  logic        [CntWidth+TotalWidth-1:0] total_ext;

  assign full  = (count_q == CntWidth'(QUEUE_DEPTH));
  assign empty = (count_q == '0);
  assign stat_o.full  = full;
  assign stat_o.empty = empty;

  // Each occupied slot compares itself with the new priority.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      less[i] = (CntWidth'(i) < count_q) && (slot_priority_q[i] < item_priority_i);
    end
  end

  always_comb begin
    slot_data_d     = slot_data_q;
    slot_priority_d = slot_priority_q;
    count_d         = count_q;
    res_data_d      = '0;
    res_prio_d      = '0;
    res_ovalid_d    = 1'b0;
    res_status_d    = ST_DONE;
    if (mode_i == MODE_INSERT) begin
      if (full) begin
        res_status_d = ST_FULL;
      end else begin
        // Keep smaller entries, drop the new word in, shift the rest back.
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (!less[i]) begin
            if (i == 0) begin
              slot_data_d[i]     = item_data_i;
              slot_priority_d[i] = item_priority_i;
            end else if (less[i-1]) begin
              slot_data_d[i]     = item_data_i;
              slot_priority_d[i] = item_priority_i;
            end else begin
              slot_data_d[i]     = slot_data_q[i-1];
              slot_priority_d[i] = slot_priority_q[i-1];
            end
          end
        end
        count_d = count_q + CntWidth'(1);
      end
    end else begin
      if (empty) begin
        res_status_d = ST_EMPTY;
      end else begin
        res_data_d   = slot_data_q[0];
        res_prio_d   = slot_priority_q[0];
        res_ovalid_d = 1'b1;
        // Advance every slot one place toward the front.
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          slot_data_d[i]     = slot_data_q[i+1];
          slot_priority_d[i] = slot_priority_q[i+1];
        end
        count_d = count_q - CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      slot_data_q     <= slot_data_d;
      slot_priority_q <= slot_priority_d;
      out_data_o      <= res_data_d;
      out_priority_o  <= res_prio_d;
      out_valid_o     <= res_ovalid_d;
      res_status_q    <= res_status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  // Count after the last word, low bits only.
  assign total_ext     = {{TotalWidth{1'b0}}, count_q};
  assign entry_total_o = total_ext[TotalWidth-1:0];
  assign status_o      = res_status_q;

endmodule

>>> sv/sorted_priority_queue.sv
// Sorted priority queue: one input word (insert or remove) gives one result word.
// For each accepted word, every slot compares its priority with the new one in
// parallel and the slot row shifts in the same edge, so a word can enter on every
// cycle unless stalled. The result sits in an output register; a new word is taken
// while it waits and is stalled only when the result is held by a stalled receiver.
// There is no clearing pass after reset; entries beyond the count are never read.
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DefaultQueueDepth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   mode_i,
  input  logic signed [spq_pkg::DataWidth-1:0]   item_data_i,
  input  logic        [spq_pkg::PrioWidth-1:0]   item_priority_i,
  output logic                                   res_valid_o,
  input  logic                                   res_stall_i,
  output logic signed [spq_pkg::DataWidth-1:0]   out_data_o,
  output logic        [spq_pkg::PrioWidth-1:0]   out_priority_o,
  output logic                                   out_valid_o,
  output logic        [spq_pkg::TotalWidth-1:0]  entry_total_o,
  output logic        [1:0]                      status_o
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mode_i          (mode_i),
    .item_data_i     (item_data_i),
    .item_priority_i (item_priority_i),
    .out_data_o      (out_data_o),
    .out_priority_o  (out_priority_o),
    .out_valid_o     (out_valid_o),
    .entry_total_o   (entry_total_o),
    .status_o        (status_o)
  );

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> res_valid_o)
    else $error("accepted word produced no result");

  a_removed_means_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && out_valid_o) |-> (status_o == ST_DONE))
    else $error("removed entry reported with error status");

  a_exec_matches_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec == (in_valid_i && !in_stall_o))
    else $error("datapath ran without an accepted word");

  a_empty_remove_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && mode_i == MODE_REMOVE && stat.empty)
      |=> (!out_valid_o && status_o == ST_EMPTY))
    else $error("remove on empty queue returned an entry");

endmodule

>>> test/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted priority queue: random traffic against an in-bench predictor.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned Depth     = DefaultQueueDepth;
  localparam int unsigned RandomOps = 1250;
  localparam int unsigned IdlePct   = 37;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned ShowLimit = 10;

  typedef struct {
    mode_e                 mode;
    logic signed [DataWidth-1:0] data;
    logic [PrioWidth-1:0]  prio;
  } queue_op_t;

  typedef struct {
    logic signed [DataWidth-1:0] data;
    logic [PrioWidth-1:0]  prio;
    logic                  vld;
    logic [TotalWidth-1:0] total;
    status_e               status;
  } queue_result_t;

  logic                        clk_i           = 1'b0;
  logic                        rst_ni          = 1'b0;
  logic                        in_valid_i      = 1'b0;
  logic                        mode_i          = 1'b0;
  logic signed [DataWidth-1:0] item_data_i     = '0;
  logic [PrioWidth-1:0]        item_priority_i = '0;
  logic                        res_stall_i     = 1'b0;
  logic                        in_stall_o;
  logic                        res_valid_o;
  logic signed [DataWidth-1:0] out_data_o;
  logic [PrioWidth-1:0]        out_priority_o;
  logic                        out_valid_o;
  logic [TotalWidth-1:0]       entry_total_o;
  logic [1:0]                  status_o;

  sorted_priority_queue #(.QUEUE_DEPTH(Depth)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .item_data_i    (item_data_i),
    .item_priority_i(item_priority_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .out_data_o     (out_data_o),
    .out_priority_o (out_priority_o),
    .out_valid_o    (out_valid_o),
    .entry_total_o  (entry_total_o),
    .status_o       (status_o)
  );

  // Predicted queue contents, front entry in slot 0.
  logic signed [DataWidth-1:0] model_data [Depth];
  logic [PrioWidth-1:0]        model_prio [Depth];
  int unsigned                 model_count = 0;

  queue_op_t     pending_ops[$];
  queue_result_t expected_results[$];
  queue_result_t oldest;
  queue_op_t     next_op;
  int            n_ops;
  int            ops_taken    = 0;
  int            results_seen = 0;
  int            mismatches   = 0;
  int            idle_cycles  = 0;
  int            cycle        = 0;
  logic          in_fire      = 1'b0;
  logic          res_fire     = 1'b0;
  logic          calm;

  function automatic queue_result_t apply_queue_op(queue_op_t op);
    queue_result_t r;
    int unsigned   pos;
    r.data   = '0;
    r.prio   = '0;
    r.vld    = 1'b0;
    r.status = ST_DONE;
    if (op.mode == MODE_INSERT) begin
      if (model_count >= Depth) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes ahead of equal priorities
        pos = 0;
        while (pos < model_count && model_prio[pos] < op.prio) pos++;
        for (int unsigned i = model_count; i > pos; i--) begin
          model_data[i] = model_data[i-1];
          model_prio[i] = model_prio[i-1];
        end
        model_data[pos] = op.data;
        model_prio[pos] = op.prio;
        model_count++;
      end
    end else if (model_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.data = model_data[0];
      r.prio = model_prio[0];
      r.vld  = 1'b1;
      for (int unsigned i = 1; i < model_count; i++) begin
        model_data[i-1] = model_data[i];
        model_prio[i-1] = model_prio[i];
      end
      model_count--;
    end
    r.total = model_count[TotalWidth-1:0];
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= ShowLimit)
        $display("mismatch in %s of result word %0d: expected %h, got %h",
                 field, results_seen, want, got);
    end
  endtask

  task automatic add_op(mode_e m, logic [31:0] d, logic [PrioWidth-1:0] p);
    queue_op_t op;
    op.mode = m;
    op.data = d;
    op.prio = p;
    pending_ops.push_back(op);
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Monitor: check result words, then predict for the accepted input word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire  = in_valid_i && !in_stall_o;
      res_fire = res_valid_o && !res_stall_i;
      if (res_fire) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= ShowLimit)
            $display("result word %0d arrived with nothing expected", results_seen);
        end else begin
          oldest = expected_results.pop_front();
          check_field("out_data", oldest.data, out_data_o);
          check_field("out_priority", oldest.prio, out_priority_o);
          check_field("out_valid", oldest.vld, out_valid_o);
          check_field("entry_total", oldest.total, entry_total_o);
          check_field("status", oldest.status, status_o);
        end
        results_seen++;
      end
      if (in_fire) begin
        next_op.mode = mode_e'(mode_i);
        next_op.data = item_data_i;
        next_op.prio = item_priority_i;
        expected_results.push_back(apply_queue_op(next_op));
        ops_taken++;
      end
      if (in_fire || res_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("tb_sorted_priority_queue NOT OK");
          $finish;
        end
      end
    end
  end

  // Driver: hold a word until taken, idle and stall at random outside the calm window.
  always @(negedge clk_i) begin
    cycle++;
    calm = (cycle >= 600 && cycle < 1400);
    if (!in_valid_i || in_fire) begin
      if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        next_op = pending_ops.pop_front();
        in_valid_i      <= 1'b1;
        mode_i          <= next_op.mode;
        item_data_i     <= next_op.data;
        item_priority_i <= next_op.prio;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    res_stall_i <= !calm && ($urandom_range(99) < IdlePct);
  end

  initial begin
    int insert_pct;
    int pick;
    logic [31:0] d;
    logic [PrioWidth-1:0] p;

    // remove on empty, extremes, ties, fill to full, insert when full
    add_op(MODE_REMOVE, 32'd0, '0);
    add_op(MODE_INSERT, 32'h7fff_ffff, 16'd100);
    add_op(MODE_INSERT, 32'h8000_0000, 16'd100);
    add_op(MODE_INSERT, 32'h0000_0000, 16'd0);
    add_op(MODE_INSERT, 32'hffff_ffff, 16'hffff);
    add_op(MODE_INSERT, 32'd5, 16'hffff);
    add_op(MODE_INSERT, 32'd6, 16'd0);
    add_op(MODE_REMOVE, 32'd0, '0);
    add_op(MODE_INSERT, $urandom, 16'd50);
    add_op(MODE_INSERT, $urandom, 16'd50);
    add_op(MODE_INSERT, $urandom, 16'd7);
    add_op(MODE_INSERT, $urandom, 16'hffff);
    add_op(MODE_INSERT, $urandom, 16'd1);
    add_op(MODE_INSERT, $urandom, 16'd200);
    add_op(MODE_INSERT, $urandom, 16'd300);
    add_op(MODE_INSERT, $urandom, 16'd300);
    add_op(MODE_INSERT, $urandom, 16'd12);
    add_op(MODE_INSERT, $urandom, 16'd13);
    add_op(MODE_INSERT, $urandom, 16'd14);
    add_op(MODE_INSERT, 32'h7fff_ffff, 16'd0);
    add_op(MODE_REMOVE, 32'd0, '0);
    add_op(MODE_REMOVE, 32'd0, '0);
    add_op(MODE_REMOVE, 32'd0, '0);

    // Shift the insert mix every 50 words so the queue swings between full and empty.
    insert_pct = 50;
    for (int k = 0; k < RandomOps; k++) begin
      if (k % 50 == 0) begin
        pick = $urandom_range(2);
        insert_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
      end
      pick = $urandom_range(99);
      if (pick < 50) p = PrioWidth'($urandom_range(7));
      else if (pick < 90) p = PrioWidth'($urandom);
      else p = $urandom_range(1) ? '1 : '0;
      pick = $urandom_range(19);
      if (pick == 0) d = 32'h8000_0000;
      else if (pick == 1) d = 32'h7fff_ffff;
      else d = $urandom;
      add_op(($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE, d, p);
    end
    n_ops = pending_ops.size();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (ops_taken == n_ops);
    wait (results_seen == ops_taken);
    repeat (8) @(posedge clk_i);
    mismatches += expected_results.size();
    if (mismatches == 0) begin
      $display("tb_sorted_priority_queue OK");
    end else begin
      $display("tb_sorted_priority_queue NOT OK");
    end
    $finish;
  end

endmodule
